// ===== rtl/core/at_response_byte_parser_unit_macros.svh =====
// Assertion macros for the AT response byte parser checker.
// Each macro expects clk_i in scope; ATRP_ASSERT also expects rst_ni.
`ifndef AT_RESPONSE_BYTE_PARSER_UNIT_MACROS_SVH
`define AT_RESPONSE_BYTE_PARSER_UNIT_MACROS_SVH

// Checked only out of reset.
`define ATRP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define ATRP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/core/atrp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atrp_pkg
// Shared types and constants of the AT response byte parser.
// ----------------------------------------------------------------------------
package atrp_pkg;

  localparam int unsigned MODE_W  = 2;
  localparam int unsigned LEN_W   = 7;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 7;
  localparam int unsigned SEC_W   = 3;
  localparam int unsigned IDX_W   = 6;
  localparam int unsigned PHASE_W = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PARSER_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAYLOAD_LENGTH = 2'd1;

  // parser modes
  localparam logic [MODE_W-1:0] MODE_IDLE    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_COMMAND = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PROMPT  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_PAYLOAD = 2'd3;

  // command parser phases
  localparam logic [PHASE_W-1:0] PH_ERROR  = 2'd0;
  localparam logic [PHASE_W-1:0] PH_ECHO   = 2'd1;
  localparam logic [PHASE_W-1:0] PH_MSG    = 2'd2;
  localparam logic [PHASE_W-1:0] PH_STATUS = 2'd3;

  // section codes
  localparam logic [SEC_W-1:0] SEC_NONE    = 3'd0;
  localparam logic [SEC_W-1:0] SEC_ECHO    = 3'd1;
  localparam logic [SEC_W-1:0] SEC_MSG     = 3'd2;
  localparam logic [SEC_W-1:0] SEC_STATUS  = 3'd3;
  localparam logic [SEC_W-1:0] SEC_PAYLOAD = 3'd4;

  // characters
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_PROMPT = 8'h3E;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic               tracking;
    logic               expect_lf;
    logic               payload_armed;
  } ctrl_t;

  typedef struct packed {
    logic             done_res;
    logic [SEC_W-1:0] section;
    logic             capture_valid;
    logic [IDX_W-1:0] capture_index;
    logic             in_error;
  } result_t;

endpackage

// ===== rtl/core/atrp_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atrp_step
// Per-byte decision logic: next parser state and result for one byte.
// ----------------------------------------------------------------------------
module atrp_step #(
  parameter int unsigned BUF_DEPTH = 64,
  parameter int unsigned CNT_W     = 7
) (
  input  logic [atrp_pkg::MODE_W-1:0] mode_i,
  input  logic [atrp_pkg::LEN_W-1:0]  length_i,
  input  logic [7:0]                  byte_i,
  input  atrp_pkg::ctrl_t             ctrl_i,
  input  logic [CNT_W-1:0]            echo_cnt_i,
  input  logic [CNT_W-1:0]            msg_cnt_i,
  input  logic [CNT_W-1:0]            status_cnt_i,
  input  logic [CNT_W-1:0]            pay_cnt_i,
  output atrp_pkg::ctrl_t             ctrl_o,
  output logic [CNT_W-1:0]            echo_cnt_o,
  output logic [CNT_W-1:0]            msg_cnt_o,
  output logic [CNT_W-1:0]            status_cnt_o,
  output logic [CNT_W-1:0]            pay_cnt_o,
  output atrp_pkg::result_t           res_o
);

  localparam int unsigned CMP_W = (CNT_W > atrp_pkg::LEN_W) ? CNT_W : atrp_pkg::LEN_W;
  localparam logic [CNT_W-1:0] DEPTH = CNT_W'(BUF_DEPTH);
  localparam logic [CNT_W-1:0] ONE   = CNT_W'(1);

  logic [7:0] expected;

  assign expected = ctrl_i.expect_lf ? atrp_pkg::CH_LF : atrp_pkg::CH_CR;

  always_comb begin
    ctrl_o       = ctrl_i;
    echo_cnt_o   = echo_cnt_i;
    msg_cnt_o    = msg_cnt_i;
    status_cnt_o = status_cnt_i;
    pay_cnt_o    = pay_cnt_i;
    res_o        = '0;

    case (mode_i)
      atrp_pkg::MODE_COMMAND: begin
        case (ctrl_i.phase)
          atrp_pkg::PH_ECHO: begin
            if (!ctrl_i.tracking) begin
              if (byte_i == atrp_pkg::CH_CR) begin
                ctrl_o.tracking  = 1'b1;
                ctrl_o.expect_lf = 1'b0;
              end else begin
                res_o.section = atrp_pkg::SEC_ECHO;
                if (echo_cnt_i < DEPTH) begin
                  res_o.capture_valid = 1'b1;
                  res_o.capture_index = atrp_pkg::IDX_W'(echo_cnt_i);
                  echo_cnt_o          = echo_cnt_i + ONE;
                end
              end
            end else if (byte_i == expected) begin
              if (byte_i == atrp_pkg::CH_CR) begin
                ctrl_o.expect_lf = 1'b1;
              end else begin
                ctrl_o.phase    = atrp_pkg::PH_MSG;
                ctrl_o.tracking = 1'b0;
              end
            end else begin
              ctrl_o.phase     = atrp_pkg::PH_ERROR;
              ctrl_o.tracking  = 1'b0;
              ctrl_o.expect_lf = 1'b0;
              echo_cnt_o       = '0;
              msg_cnt_o        = '0;
              status_cnt_o     = '0;
            end
          end
          atrp_pkg::PH_MSG: begin
            if (!ctrl_i.tracking) begin
              if (byte_i == atrp_pkg::CH_CR) begin
                ctrl_o.tracking  = 1'b1;
                ctrl_o.expect_lf = 1'b1;
              end else begin
                res_o.section = atrp_pkg::SEC_MSG;
                if (msg_cnt_i < DEPTH) begin
                  res_o.capture_valid = 1'b1;
                  res_o.capture_index = atrp_pkg::IDX_W'(msg_cnt_i);
                  msg_cnt_o           = msg_cnt_i + ONE;
                end
              end
            end else if (byte_i == expected) begin
              ctrl_o.phase     = atrp_pkg::PH_STATUS;
              ctrl_o.tracking  = 1'b0;
              ctrl_o.expect_lf = 1'b0;
            end else begin
              ctrl_o.phase     = atrp_pkg::PH_ERROR;
              ctrl_o.tracking  = 1'b0;
              ctrl_o.expect_lf = 1'b0;
              echo_cnt_o       = '0;
              msg_cnt_o        = '0;
              status_cnt_o     = '0;
            end
          end
          atrp_pkg::PH_STATUS: begin
            if (!ctrl_i.tracking) begin
              if (byte_i == expected) begin
                ctrl_o.tracking  = 1'b1;
                ctrl_o.expect_lf = 1'b1;
              end else begin
                res_o.section = atrp_pkg::SEC_STATUS;
                if (status_cnt_i < DEPTH) begin
                  res_o.capture_valid = 1'b1;
                  res_o.capture_index = atrp_pkg::IDX_W'(status_cnt_i);
                  status_cnt_o        = status_cnt_i + ONE;
                end
              end
            end else if (byte_i == expected) begin
              if (status_cnt_i == '0) begin
                // empty status line: skip it
                ctrl_o.tracking  = 1'b0;
                ctrl_o.expect_lf = 1'b0;
              end else begin
                ctrl_o.phase     = atrp_pkg::PH_ECHO;
                ctrl_o.tracking  = 1'b0;
                ctrl_o.expect_lf = 1'b0;
                echo_cnt_o       = '0;
                msg_cnt_o        = '0;
                status_cnt_o     = '0;
                res_o.done_res   = 1'b1;
              end
            end
            // after CR, stray bytes are ignored until LF
          end
          default: begin
            // error phase absorbs everything
          end
        endcase
      end
      atrp_pkg::MODE_PROMPT: begin
        res_o.done_res = (byte_i == atrp_pkg::CH_PROMPT);
      end
      atrp_pkg::MODE_PAYLOAD: begin
        if (byte_i == atrp_pkg::CH_PLUS) begin
          ctrl_o.tracking = 1'b1;
        end else if (ctrl_i.tracking) begin
          if (byte_i == atrp_pkg::CH_COLON) begin
            ctrl_o.payload_armed = 1'b1;
            pay_cnt_o            = '0;
          end else if (ctrl_i.payload_armed) begin
            res_o.section = atrp_pkg::SEC_PAYLOAD;
            if (pay_cnt_i < DEPTH) begin
              res_o.capture_valid = 1'b1;
              res_o.capture_index = atrp_pkg::IDX_W'(pay_cnt_i);
              pay_cnt_o           = pay_cnt_i + ONE;
            end
            if (CMP_W'(pay_cnt_o) == CMP_W'(length_i)) begin
              ctrl_o.payload_armed = 1'b0;
              ctrl_o.tracking      = 1'b0;
              res_o.done_res       = 1'b1;
            end
          end
        end
      end
      default: begin
        // idle mode never completes
      end
    endcase

    res_o.in_error = (ctrl_o.phase == atrp_pkg::PH_ERROR);
  end

endmodule

// ===== rtl/core/at_response_byte_parser_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// at_response_byte_parser_unit
// Classifies modem response bytes under a configured parser mode.
// ----------------------------------------------------------------------------
// Accepts one received byte per clock while in_stall_o is low and returns
// one result per byte, in order, through the input register and then the
// output register. The step logic decides the next parser state and the
// result in a single pass into the output register, so throughput is one
// byte per cycle while the output is not stalled. A stalled output holds
// its result while the input register still takes one more byte. The user
// must write configuration (parser_mode, payload_length) through the plain
// write port only while no byte is in flight; the block does not enforce
// this. A change of mode resets nothing. Section counts saturate at BUF_DEPTH.
// ----------------------------------------------------------------------------
module at_response_byte_parser_unit #(
  parameter int unsigned BUF_DEPTH = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write port
  input  logic                           cfg_we_i,
  input  logic [atrp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [atrp_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // byte request channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [7:0]                     rx_byte_i,
  // result request channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           done_res_o,
  output logic [atrp_pkg::SEC_W-1:0]     section_o,
  output logic                           capture_valid_o,
  output logic [atrp_pkg::IDX_W-1:0]     capture_index_o,
  output logic [7:0]                     capture_byte_o,
  output logic                           in_error_o
);

  // counts must hold BUF_DEPTH itself (saturation value)
  localparam int unsigned CNT_W = $clog2(BUF_DEPTH + 1);

  // configuration registers
  logic [atrp_pkg::MODE_W-1:0] mode_q;
  logic [atrp_pkg::LEN_W-1:0]  length_q;

  // parser state
  atrp_pkg::ctrl_t  ctrl_q, ctrl_d;
  logic [CNT_W-1:0] echo_cnt_q, echo_cnt_d;
  logic [CNT_W-1:0] msg_cnt_q, msg_cnt_d;
  logic [CNT_W-1:0] status_cnt_q, status_cnt_d;
  logic [CNT_W-1:0] pay_cnt_q, pay_cnt_d;

  // pipeline
  logic              in_valid_q;
  logic [7:0]        in_byte_q;
  logic              out_valid_q;
  atrp_pkg::result_t res_d, res_q;
  logic [7:0]        out_byte_q;

  logic in_fire;
  logic out_load;

  // the output register takes a new result when empty or being drained
  assign out_load   = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !out_load;
  assign in_fire    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= atrp_pkg::MODE_IDLE;
      length_q <= atrp_pkg::LEN_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        atrp_pkg::REG_PARSER_MODE:    mode_q   <= cfg_data_i[atrp_pkg::MODE_W-1:0];
        atrp_pkg::REG_PAYLOAD_LENGTH: length_q <= cfg_data_i[atrp_pkg::LEN_W-1:0];
        default: begin
          // unmapped index: ignored
        end
      endcase
    end
  end

  atrp_step #(
    .BUF_DEPTH (BUF_DEPTH),
    .CNT_W     (CNT_W)
  ) u_step (
    .mode_i       (mode_q),
    .length_i     (length_q),
    .byte_i       (in_byte_q),
    .ctrl_i       (ctrl_q),
    .echo_cnt_i   (echo_cnt_q),
    .msg_cnt_i    (msg_cnt_q),
    .status_cnt_i (status_cnt_q),
    .pay_cnt_i    (pay_cnt_q),
    .ctrl_o       (ctrl_d),
    .echo_cnt_o   (echo_cnt_d),
    .msg_cnt_o    (msg_cnt_d),
    .status_cnt_o (status_cnt_d),
    .pay_cnt_o    (pay_cnt_d),
    .res_o        (res_d)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      ctrl_q       <= '{phase: atrp_pkg::PH_ECHO, tracking: 1'b0,
                        expect_lf: 1'b0, payload_armed: 1'b0};
      echo_cnt_q   <= '0;
      msg_cnt_q    <= '0;
      status_cnt_q <= '0;
      pay_cnt_q    <= '0;
    end else begin
      if (in_fire) begin
        in_valid_q <= 1'b1;
      end else if (out_load) begin
        in_valid_q <= 1'b0;
      end

      if (out_load) begin
        out_valid_q  <= 1'b1;
        ctrl_q       <= ctrl_d;
        echo_cnt_q   <= echo_cnt_d;
        msg_cnt_q    <= msg_cnt_d;
        status_cnt_q <= status_cnt_d;
        pay_cnt_q    <= pay_cnt_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_byte_q <= rx_byte_i;
    end
    if (out_load) begin
      res_q      <= res_d;
      out_byte_q <= in_byte_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign done_res_o      = res_q.done_res;
  assign section_o       = res_q.section;
  assign capture_valid_o = res_q.capture_valid;
  assign capture_index_o = res_q.capture_index;
  assign capture_byte_o  = out_byte_q;
  assign in_error_o      = res_q.in_error;

endmodule

// ===== rtl/core/atrp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atrp_checker
// Port-level checks of the AT response byte parser, bound to the top level.
// ----------------------------------------------------------------------------
`include "at_response_byte_parser_unit_macros.svh"

module atrp_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic                           done_res_o,
  input logic [atrp_pkg::SEC_W-1:0]     section_o,
  input logic                           capture_valid_o,
  input logic [atrp_pkg::IDX_W-1:0]     capture_index_o,
  input logic [7:0]                     capture_byte_o,
  input logic                           in_error_o
);

  // stalled result holds
  property p_out_hold;
    out_valid_o && out_stall_i |=> out_valid_o && $stable(done_res_o)
      && $stable(section_o) && $stable(capture_valid_o) && $stable(capture_index_o)
      && $stable(capture_byte_o) && $stable(in_error_o);
  endproperty

  // a captured byte always belongs to a section
  property p_cap_section;
    out_valid_o && capture_valid_o |-> section_o != atrp_pkg::SEC_NONE;
  endproperty

  // index is zero when nothing is captured
  property p_idx_zero;
    out_valid_o && !capture_valid_o |-> capture_index_o == '0;
  endproperty

  // error phase is left only by reset
  property p_err_sticky;
    out_valid_o && in_error_o |=> !out_valid_o || in_error_o;
  endproperty

  // once reset has been seen at an edge, no result is offered at the next one
  property p_rst_quiet;
    !rst_ni |=> !out_valid_o;
  endproperty

  `ATRP_ASSERT(a_out_hold, p_out_hold, "stalled result changed")

  `ATRP_ASSERT(a_cap_section, p_cap_section, "capture without section")

  `ATRP_ASSERT(a_idx_zero, p_idx_zero, "index set without capture")

  `ATRP_ASSERT(a_err_sticky, p_err_sticky, "left error phase")

  `ATRP_ASSERT_ALWAYS(a_rst_quiet, p_rst_quiet, "result valid in reset")

endmodule

bind at_response_byte_parser_unit atrp_checker u_atrp_checker (.*);

// ===== tb/sv/at_response_byte_parser_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// at_response_byte_parser_unit_tb
// Self-checking bench for the AT response byte parser.
// ----------------------------------------------------------------------------
// Streams modem bytes through the valid/stall request channel under every
// parser mode and checks each result request against an in-bench parser
// model. The stream is mostly well-formed traffic: command responses, payload
// frames and prompts, with random content. Mode and length changes go through
// the write port only while nothing is in flight. Command mode is broken on
// purpose only near the end, since its error phase is left only by reset.
// Both sides idle in random bursts, except during the tail.
// ----------------------------------------------------------------------------
module at_response_byte_parser_unit_tb;
  import atrp_pkg::*;

  localparam int unsigned BUF_DEPTH = 64;
  localparam int unsigned SETTLE_CYCLES = 3;   // idle cycles before a write
  localparam int unsigned DRAIN_CYCLES = 8;    // pipeline is two deep
  localparam int unsigned STUCK_LIMIT = 2000;  // cycles with no handshake
  localparam int unsigned RANDOM_TARGET = 590;
  localparam int unsigned QUIET_TAIL = 120;    // no idling over the last bytes

  // indexes past the two registers; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  typedef enum logic {ACT_BYTE, ACT_REG} act_kind_e;

  typedef struct packed {
    act_kind_e             kind;
    logic [7:0]            rx;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } rx_act_t;

  typedef struct packed {
    logic             done;
    logic [SEC_W-1:0] section;
    logic             cap_valid;
    logic [IDX_W-1:0] cap_index;
    logic [7:0]       cap_byte;
    logic             in_err;
  } parse_out_t;

  logic                  clk_i;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [7:0]            rx_byte_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic                  done_res_o;
  logic [SEC_W-1:0]      section_o;
  logic                  capture_valid_o;
  logic [IDX_W-1:0]      capture_index_o;
  logic [7:0]            capture_byte_o;
  logic                  in_error_o;

  at_response_byte_parser_unit #(
    .BUF_DEPTH(BUF_DEPTH)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .done_res_o     (done_res_o),
    .section_o      (section_o),
    .capture_valid_o(capture_valid_o),
    .capture_index_o(capture_index_o),
    .capture_byte_o (capture_byte_o),
    .in_error_o     (in_error_o)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // --------------------------------------------------------------------------
  // Parser model: mirrors the block's registers and state.
  // --------------------------------------------------------------------------
  logic [MODE_W-1:0]  cur_mode = MODE_IDLE;
  logic [LEN_W-1:0]   cur_len = 7'd1;
  logic [PHASE_W-1:0] cmd_phase = PH_ECHO;
  logic               marker_seen = 1'b0;  // shared by command and payload
  logic               await_lf = 1'b0;
  logic               pay_open = 1'b0;
  logic [6:0]         fill [1:4] = '{default: '0};  // per-section byte counts

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_PARSER_MODE:    cur_mode = data[MODE_W-1:0];
      REG_PAYLOAD_LENGTH: cur_len = data;
      default: ;
    endcase
  endfunction

  function automatic void drop_command(input logic [PHASE_W-1:0] ph);
    cmd_phase = ph;
    marker_seen = 1'b0;
    await_lf = 1'b0;
    fill[SEC_ECHO] = '0;
    fill[SEC_MSG] = '0;
    fill[SEC_STATUS] = '0;
  endfunction

  // count saturates at the buffer depth; a full section still reports itself
  function automatic parse_out_t take(input logic [SEC_W-1:0] sec, input parse_out_t r);
    r.section = sec;
    if (fill[sec] < BUF_DEPTH) begin
      r.cap_valid = 1'b1;
      r.cap_index = fill[sec][IDX_W-1:0];
      fill[sec] = fill[sec] + 7'd1;
    end
    return r;
  endfunction

  function automatic parse_out_t parse_byte(input logic [7:0] b);
    parse_out_t r;
    logic [7:0] term;
    r = '0;
    r.cap_byte = b;
    term = await_lf ? CH_LF : CH_CR;
    case (cur_mode)
      MODE_COMMAND: begin
        case (cmd_phase)
          PH_ECHO: begin
            if (!marker_seen) begin
              if (b == CH_CR) begin
                marker_seen = 1'b1;
                await_lf = 1'b0;
              end else begin
                r = take(SEC_ECHO, r);
              end
            end else if (b == term) begin
              if (b == CH_CR) begin
                await_lf = 1'b1;
              end else begin
                cmd_phase = PH_MSG;
                marker_seen = 1'b0;
              end
            end else begin
              drop_command(PH_ERROR);
            end
          end
          PH_MSG: begin
            if (!marker_seen) begin
              if (b == CH_CR) begin
                marker_seen = 1'b1;
                await_lf = 1'b1;
              end else begin
                r = take(SEC_MSG, r);
              end
            end else if (b == term) begin
              cmd_phase = PH_STATUS;
              marker_seen = 1'b0;
              await_lf = 1'b0;
            end else begin
              drop_command(PH_ERROR);
            end
          end
          PH_STATUS: begin
            if (!marker_seen) begin
              if (b == term) begin
                await_lf = 1'b1;
                marker_seen = 1'b1;
              end else begin
                r = take(SEC_STATUS, r);
              end
            end else if (b == term) begin
              // empty status lines are skipped
              if (fill[SEC_STATUS] == 0) begin
                marker_seen = 1'b0;
                await_lf = 1'b0;
              end else begin
                drop_command(PH_ECHO);
                r.done = 1'b1;
              end
            end
            // other bytes after the CR are ignored
          end
          default: ;  // error phase absorbs everything
        endcase
      end
      MODE_PROMPT: r.done = (b == CH_PROMPT);
      MODE_PAYLOAD: begin
        if (b == CH_PLUS) begin
          marker_seen = 1'b1;
        end else if (marker_seen) begin
          if (b == CH_COLON) begin
            pay_open = 1'b1;
            fill[SEC_PAYLOAD] = '0;
          end else if (pay_open) begin
            r = take(SEC_PAYLOAD, r);
            if (fill[SEC_PAYLOAD] == cur_len) begin
              pay_open = 1'b0;
              marker_seen = 1'b0;
              r.done = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
    r.in_err = (cmd_phase == PH_ERROR);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus stream: bytes and register writes in issue order.
  // --------------------------------------------------------------------------
  rx_act_t     rx_stream [$];
  parse_out_t  parse_due [$];
  int unsigned n_bytes = 0;
  int unsigned bytes_left = 0;
  int unsigned n_sent = 0;
  int unsigned n_seen = 0;
  int unsigned n_mismatch = 0;
  logic        quiet = 1'b0;
  int unsigned idle_odds = 0;

  task automatic push_byte(input logic [7:0] b);
    rx_stream.push_back('{kind: ACT_BYTE, rx: b, idx: '0, data: '0});
    n_bytes++;
  endtask

  task automatic push_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    rx_stream.push_back('{kind: ACT_REG, rx: '0, idx: idx, data: data});
  endtask

  function automatic logic [7:0] byte_not(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] v;
    do v = 8'($urandom_range(0, 255)); while (v == a || v == b);
    return v;
  endfunction

  task automatic push_text(input int n, input logic [7:0] avoid);
    repeat (n) push_byte(byte_not(avoid, avoid));
  endtask

  // well-formed response: echo CR CR LF, message CR LF, empty lines, status
  task automatic push_response();
    int n;
    n = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 6);
    push_text(n, CH_CR);
    push_byte(CH_CR);
    push_byte(CH_CR);
    push_byte(CH_LF);
    push_text($urandom_range(0, 6), CH_CR);
    push_byte(CH_CR);
    push_byte(CH_LF);
    repeat ($urandom_range(0, 2)) begin
      push_byte(CH_CR);
      push_text($urandom_range(0, 1), CH_LF);
      push_byte(CH_LF);
    end
    push_text($urandom_range(1, 5), CH_CR);
    push_byte(CH_CR);
    push_text($urandom_range(0, 2), CH_LF);
    push_byte(CH_LF);
  endtask

  // clean frame completes and clears the marker when len is the programmed length
  task automatic push_clean_frame(input int len);
    push_byte(CH_PLUS);
    push_byte(CH_COLON);
    repeat (len) push_byte(byte_not(CH_PLUS, CH_COLON));
  endtask

  task automatic push_noisy_frame(input int len);
    logic [7:0] b;
    repeat ($urandom_range(0, 3)) push_byte(8'($urandom_range(0, 255)));
    push_byte(CH_PLUS);
    repeat ($urandom_range(0, 2)) push_byte(byte_not(CH_COLON, CH_COLON));
    push_byte(CH_COLON);
    repeat (len + $urandom_range(0, 2) - 1) begin
      case ($urandom_range(0, 11))
        0:       b = CH_PLUS;
        1:       b = CH_COLON;
        default: b = 8'($urandom_range(0, 255));
      endcase
      push_byte(b);
    end
  endtask

  // --------------------------------------------------------------------------
  // Idle pacing: idle density changes at random intervals, zero included.
  // --------------------------------------------------------------------------
  int unsigned pace_left = 0;

  always @(posedge clk_i) begin
    if (pace_left == 0) begin
      pace_left <= $urandom_range(20, 80);
      case ($urandom_range(0, 3))
        0:       idle_odds <= 0;
        1:       idle_odds <= 2;
        2:       idle_odds <= 5;
        default: idle_odds <= 12;
      endcase
    end else begin
      pace_left <= pace_left - 1;
    end
  end

  // --------------------------------------------------------------------------
  // Driver: presents bytes, issues register writes once the pipe is empty.
  // --------------------------------------------------------------------------
  int unsigned gap = 0;
  int unsigned settle = 0;

  always @(posedge clk_i) begin : drive_rx
    logic       nxt_valid;
    logic [7:0] nxt_byte;
    logic       nxt_we;
    rx_act_t    head;
    nxt_valid = in_valid_i;
    nxt_byte = rx_byte_i;
    nxt_we = 1'b0;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        void'(rx_stream.pop_front());
        n_sent++;
        bytes_left--;
        nxt_valid = 1'b0;
      end
      // n_seen may lag by a step; that only delays a write
      if (n_sent == n_seen && !nxt_valid) settle++;
      else settle = 0;
      if (!nxt_valid && rx_stream.size() != 0) begin
        head = rx_stream[0];
        if (head.kind == ACT_REG) begin
          if (settle >= SETTLE_CYCLES) begin
            apply_reg(head.idx, head.data);
            cfg_idx_i <= head.idx;
            cfg_data_i <= head.data;
            nxt_we = 1'b1;
            void'(rx_stream.pop_front());
            settle = 0;
          end
        end else if (gap != 0) begin
          gap--;
        end else if (!quiet && idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
          gap = $urandom_range(0, 17);
        end else begin
          nxt_valid = 1'b1;
          nxt_byte = head.rx;
        end
      end
      quiet <= (bytes_left <= QUIET_TAIL);
    end
    in_valid_i <= nxt_valid;
    rx_byte_i <= nxt_byte;
    cfg_we_i <= nxt_we;
  end

  // --------------------------------------------------------------------------
  // Monitor: checks result requests, then predicts for accepted bytes.
  // --------------------------------------------------------------------------
  int unsigned hold = 0;

  task automatic report(input string what, input logic [7:0] want, input logic [7:0] got);
    $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
    n_mismatch++;
  endtask

  always @(posedge clk_i) begin : check_parse
    parse_out_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (parse_due.size() == 0) begin
          $display("%0t: result with no byte pending, expected none, got byte %0h",
                   $time, capture_byte_o);
          n_mismatch++;
        end else begin
          want = parse_due.pop_front();
          n_seen++;
          if (done_res_o !== want.done) report("done_res", want.done, done_res_o);
          if (section_o !== want.section) report("section", want.section, section_o);
          if (capture_valid_o !== want.cap_valid)
            report("capture_valid", want.cap_valid, capture_valid_o);
          if (capture_index_o !== want.cap_index)
            report("capture_index", want.cap_index, capture_index_o);
          if (capture_byte_o !== want.cap_byte)
            report("capture_byte", want.cap_byte, capture_byte_o);
          if (in_error_o !== want.in_err) report("in_error", want.in_err, in_error_o);
        end
      end
      if (in_valid_i && !in_stall_o) parse_due.push_back(parse_byte(rx_byte_i));
      if (hold != 0) begin
        hold--;
        out_stall_i <= 1'b1;
      end else if (!quiet && idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
        hold = $urandom_range(0, 17);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // no handshake of any kind for too long means a hang
  int unsigned stuck = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
        stuck <= 0;
      end else if (stuck == STUCK_LIMIT) begin
        $display("at_response_byte_parser_unit_tb NOT OK");
        $finish;
      end else begin
        stuck <= stuck + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : run_test
    int len;
    int pick;

    // reset mode is idle: nothing completes, not even a prompt
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(CH_PROMPT);
    push_reg(REG_PARSER_MODE, CFG_DATA_W'(MODE_PROMPT));
    push_byte(CH_PROMPT);
    push_byte(8'h3F);
    push_byte(8'h7F);
    // writes past the register file are dropped
    push_reg(REG_SPARE_2, 7'h7F);
    push_reg(REG_SPARE_3, 7'h00);
    push_byte(CH_PROMPT);
    // payload with reset length; '+' while armed is a marker, not data
    push_reg(REG_PARSER_MODE, CFG_DATA_W'(MODE_PAYLOAD));
    push_byte(8'h80);
    push_byte(CH_PLUS);
    push_byte(CH_COLON);
    push_byte(CH_PLUS);
    push_byte(8'h55);
    // command mode, upper data bits ignored; empty message and empty status
    // line with junk after its CR, then a one-byte status
    push_reg(REG_PARSER_MODE, {5'h1F, MODE_COMMAND});
    push_byte(8'h41);
    push_byte(CH_CR);
    push_byte(CH_CR);
    push_byte(CH_LF);
    push_byte(CH_CR);
    push_byte(CH_LF);
    push_byte(CH_CR);
    push_byte(8'h99);
    push_byte(CH_LF);
    push_byte(8'h4F);
    push_byte(CH_CR);
    push_byte(8'h00);
    push_byte(CH_LF);

    // random phases; every phase leaves the shared marker clear
    while (n_bytes < RANDOM_TARGET) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        push_reg(REG_PARSER_MODE, CFG_DATA_W'(MODE_IDLE));
        repeat ($urandom_range(5, 15)) push_byte(8'($urandom_range(0, 255)));
      end else if (pick <= 2) begin
        push_reg(REG_PARSER_MODE, CFG_DATA_W'(MODE_PROMPT));
        repeat ($urandom_range(5, 15))
          push_byte(($urandom_range(0, 3) == 0) ? CH_PROMPT : 8'($urandom_range(0, 255)));
      end else if (pick <= 5) begin
        push_reg(REG_PARSER_MODE, {5'($urandom_range(0, 31)), MODE_COMMAND});
        repeat ($urandom_range(1, 3)) push_response();
      end else begin
        len = ($urandom_range(0, 7) == 0) ? BUF_DEPTH : $urandom_range(1, 8);
        push_reg(REG_PAYLOAD_LENGTH, CFG_DATA_W'(len));
        push_reg(REG_PARSER_MODE, CFG_DATA_W'(MODE_PAYLOAD));
        if (len < BUF_DEPTH) repeat ($urandom_range(0, 3)) push_noisy_frame(len);
        push_clean_frame(len);
      end
    end

    // tail: break a delimiter, then show the error phase absorbs everything
    push_reg(REG_PARSER_MODE, CFG_DATA_W'(MODE_COMMAND));
    push_text($urandom_range(0, 3), CH_CR);
    case ($urandom_range(0, 2))
      0: begin
        push_byte(CH_CR);
        push_byte(byte_not(CH_CR, CH_CR));
      end
      1: begin
        push_byte(CH_CR);
        push_byte(CH_CR);
        push_byte(byte_not(CH_LF, CH_LF));
      end
      default: begin
        push_byte(CH_CR);
        push_byte(CH_CR);
        push_byte(CH_LF);
        push_text($urandom_range(0, 3), CH_CR);
        push_byte(CH_CR);
        push_byte(byte_not(CH_LF, CH_LF));
      end
    endcase
    repeat (20) begin
      case ($urandom_range(0, 2))
        0:       push_byte(CH_CR);
        1:       push_byte(CH_LF);
        default: push_byte(8'($urandom_range(0, 255)));
      endcase
    end
    // error flag shows in every mode
    push_reg(REG_PARSER_MODE, CFG_DATA_W'(MODE_PROMPT));
    push_byte(CH_PROMPT);
    push_byte(8'h01);
    // unreachable lengths never complete; the long run saturates the count
    push_reg(REG_PAYLOAD_LENGTH, 7'd0);
    push_reg(REG_PARSER_MODE, CFG_DATA_W'(MODE_PAYLOAD));
    push_clean_frame(10);
    push_reg(REG_PAYLOAD_LENGTH, 7'h7F);
    push_clean_frame(BUF_DEPTH + 4);
    push_reg(REG_PARSER_MODE, CFG_DATA_W'(MODE_IDLE));
    push_byte(CH_PLUS);
    push_byte(8'hFF);

    bytes_left = n_bytes;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (rx_stream.size() != 0 || n_seen != n_sent) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (n_mismatch == 0 && parse_due.size() == 0) begin
      $display("at_response_byte_parser_unit_tb OK");
    end else begin
      $display("at_response_byte_parser_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
